// ----- design/lcm_pkg.sv -----
// lcm_pkg: shared types, register codes and reset constants of the lc level meter
// used by every module of the block; depends on nothing

package lcm_pkg;

    // default widths of the counters
    localparam int COUNT_BITS_DEF = 24;
    localparam int GATE_BITS_DEF  = 16;

    // depth of the small queues between the parts
    localparam int QUEUE_DEPTH = 2;

    // dividend width of the shared divider (numerator, and 16 x 32 product)
    localparam int NUM_BITS = 48;

    // register file
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;

    localparam logic [15:0]         GATE_TOP_RST   = 16'd46838;
    localparam logic [NUM_BITS-1:0] CAP_NUM_RST    = 48'd25354969574036;
    localparam logic [15:0]         CAP_OFFSET_RST = 16'd200;
    localparam logic [15:0]         CAP_MIN_RST    = 16'd0;
    localparam logic [15:0]         CAP_MAX_RST    = 16'd0;
    localparam logic [15:0]         HEIGHT_MAX_RST = 16'd0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GATE_TOP   = 3'd0,
        CFG_CAP_NUM    = 3'd1,
        CFG_CAP_OFFSET = 3'd2,
        CFG_CAP_MIN    = 3'd3,
        CFG_CAP_MAX    = 3'd4,
        CFG_HEIGHT_MAX = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]         gate_top;
        logic [NUM_BITS-1:0] cap_numerator;
        logic [15:0]         cap_offset;
        logic [15:0]         cap_min;
        logic [15:0]         cap_max;
        logic [15:0]         height_max;
    } t_cfg;

    typedef struct packed {
        logic sensor_edge;
        logic gate_tick;
    } t_in_item;

    typedef struct packed {
        logic [23:0] edge_total;
        logic [31:0] capacitance;
        logic [15:0] level_mm;
        logic        no_signal;
        logic        bad_calibration;
    } t_out_item;

    // back-end sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_DIV_CAP,
        ST_CAP,
        ST_SPAN,
        ST_MUL,
        ST_DIV_LVL,
        ST_EMIT
    } t_back_state;

endpackage

// ----- design/lcm_queue.sv -----
// lcm_queue: small first-in first-out queue of flat words
// no dependencies beyond lcm_pkg for the default depth

module lcm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lcm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    import lcm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wdata;
        end
    end

endmodule

// ----- design/lcm_front.sv -----
// lcm_front: edge counter and gate tick counter; emits the edge count at gate end
// depends on lcm_pkg

module lcm_front #(
    parameter int COUNT_BITS = lcm_pkg::COUNT_BITS_DEF,
    parameter int GATE_BITS  = lcm_pkg::GATE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [15:0]           i_gate_top,
    input  logic                  i_accept,
    input  lcm_pkg::t_in_item     i_item,
    output logic                  o_job_push,
    output logic [COUNT_BITS-1:0] o_job_count
);
    import lcm_pkg::*;

    localparam int TW = (GATE_BITS > 16) ? GATE_BITS : 16;
    localparam logic [TW-1:0] GATE_MAX = TW'((64'd1 << GATE_BITS) - 64'd1);

    logic [COUNT_BITS-1:0] r_edge_cnt, n_edge_cnt;
    logic [GATE_BITS-1:0]  r_gate_cnt, n_gate_cnt;
    logic [COUNT_BITS-1:0] edge_inc;
    logic [TW-1:0]         top_req;
    logic [TW-1:0]         top;
    logic                  gate_end;

    assign top_req  = TW'(i_gate_top);
    assign top      = (top_req > GATE_MAX) ? GATE_MAX : top_req;
    // an edge on the closing tick belongs to the gate that ends
    assign edge_inc = r_edge_cnt + COUNT_BITS'(i_item.sensor_edge);
    assign gate_end = i_accept && i_item.gate_tick && !(TW'(r_gate_cnt) < top);

    always_comb begin
        n_edge_cnt = r_edge_cnt;
        n_gate_cnt = r_gate_cnt;
        if (i_accept) begin
            n_edge_cnt = edge_inc;
            if (i_item.gate_tick) begin
                if (gate_end) begin
                    n_edge_cnt = '0;
                    n_gate_cnt = '0;
                end else begin
                    n_gate_cnt = r_gate_cnt + 1'b1;
                end
            end
        end
    end

    assign o_job_push  = gate_end;
    assign o_job_count = edge_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_cnt <= '0;
            r_gate_cnt <= '0;
        end else begin
            r_edge_cnt <= n_edge_cnt;
            r_gate_cnt <= n_gate_cnt;
        end
    end

endmodule

// ----- design/lcm_back.sv -----
// lcm_back: sequencer turning one edge count into capacitance and fill level
// one shared restoring divider, one bit per cycle; depends on lcm_pkg

module lcm_back #(
    parameter int COUNT_BITS = lcm_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lcm_pkg::t_cfg         i_cfg,
    input  logic                  i_job_empty,
    input  logic [COUNT_BITS-1:0] i_job_count,
    output logic                  o_job_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output lcm_pkg::t_out_item    o_res
);
    import lcm_pkg::*;

    localparam int DW = 2 * COUNT_BITS;
    localparam int CW = $clog2(NUM_BITS);

    t_back_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_count;
    logic [DW-1:0]         r_rem;
    logic [DW-1:0]         r_den;
    logic [NUM_BITS-1:0]   r_quo;
    logic [CW-1:0]         r_bit_cnt;
    logic [31:0]           r_cap;
    logic [31:0]           r_span;
    logic                  r_none;
    logic                  r_bad;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_diff;
    logic          fits;
    logic [31:0]   q_sat;
    logic [31:0]   offset_w;
    logic [31:0]   min_w;
    logic [31:0]   count_w;
    logic [15:0]   level;

    // divider step
    assign rem_sh   = {r_rem, r_quo[NUM_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, r_den};
    assign fits     = !rem_diff[DW];

    assign q_sat    = (r_quo[NUM_BITS-1:32] != '0) ? 32'hFFFF_FFFF : r_quo[31:0];
    assign offset_w = 32'(i_cfg.cap_offset);
    assign min_w    = 32'(i_cfg.cap_min);
    assign count_w  = 32'(r_count);
    assign level    = r_bad ? 16'd0 :
                      ((r_quo[NUM_BITS-1:16] != '0) ? 16'hFFFF : r_quo[15:0]);

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = ST_SQUARE;
                end
            end
            ST_SQUARE:  n_state = ST_DIV_CAP;
            ST_DIV_CAP: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_CAP;
                end
            end
            ST_CAP:  n_state = ST_SPAN;
            ST_SPAN: n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV_LVL;
            ST_DIV_LVL: begin
                if (r_bit_cnt == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_job_empty) begin
                    r_count <= i_job_count;
                end
            end
            ST_SQUARE: begin
                r_den     <= DW'(r_count) * DW'(r_count);
                r_rem     <= '0;
                r_quo     <= i_cfg.cap_numerator;
                r_bit_cnt <= CW'(NUM_BITS - 1);
                r_none    <= (r_count == '0);
            end
            ST_DIV_CAP, ST_DIV_LVL: begin
                r_rem     <= fits ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
                r_quo     <= {r_quo[NUM_BITS-2:0], fits};
                r_bit_cnt <= r_bit_cnt - 1'b1;
            end
            ST_CAP: begin
                // no edges: capacitance pinned at full scale
                if (r_none) begin
                    r_cap <= 32'hFFFF_FFFF;
                end else if (q_sat > offset_w) begin
                    r_cap <= q_sat - offset_w;
                end else begin
                    r_cap <= '0;
                end
                r_bad <= !(i_cfg.cap_max > i_cfg.cap_min);
            end
            ST_SPAN: begin
                // clamp below at cap_min, then distance above it
                r_span <= (r_cap < min_w) ? 32'd0 : (r_cap - min_w);
            end
            ST_MUL: begin
                r_quo     <= NUM_BITS'(i_cfg.height_max) * NUM_BITS'(r_span);
                r_den     <= DW'(i_cfg.cap_max - i_cfg.cap_min);
                r_rem     <= '0;
                r_bit_cnt <= CW'(NUM_BITS - 1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.edge_total      = count_w[23:0];
        o_res.capacitance     = r_cap;
        o_res.level_mm        = level;
        o_res.no_signal       = r_none;
        o_res.bad_calibration = r_bad;
    end

endmodule

// ----- design/lc_capacitive_level_meter_top.sv -----
// lc_capacitive_level_meter_top: gated lc oscillator counter with capacitance and level math
// instantiates lcm_front, lcm_queue, lcm_back; depends on lcm_pkg
//
// channel   direction  handshake            payload
// request   in         push / full          i_in_item   (sensor_edge, gate_tick)
// result    out        pop / empty          o_out_item  (edge_total .. bad_calibration)
// config    in         i_cfg_we, no wait    i_cfg_idx, i_cfg_wdata
//
// the front takes one request per clock while full is low; counters update in the same edge
// each gate end costs the back two 48-step divides on one shared bit-serial divider
// full rises only when two gate edge counts wait in the job queue behind the divider
// reset (synchronous, active low) clears counters, queues, sequencer, registers
// the result queue lets the back keep working while pop is held low

module lc_capacitive_level_meter_top #(
    parameter int COUNT_BITS = lcm_pkg::COUNT_BITS_DEF,
    parameter int GATE_BITS  = lcm_pkg::GATE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                push,
    output logic                                full,
    input  lcm_pkg::t_in_item                   i_in_item,
    // result side
    output logic                                empty,
    input  logic                                pop,
    output lcm_pkg::t_out_item                  o_out_item,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [lcm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [lcm_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import lcm_pkg::*;

    localparam int OUT_W = $bits(t_out_item);

    t_cfg                  r_cfg;
    logic                  accept;
    logic                  job_push;
    logic [COUNT_BITS-1:0] job_count_in;
    logic                  job_full;
    logic                  job_empty;
    logic                  job_pop;
    logic [COUNT_BITS-1:0] job_count_out;
    logic                  res_push;
    logic                  res_full;
    t_out_item             res_item;
    logic [OUT_W-1:0]      res_rdata;

    // register file; the user must write it only while the block is idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_top      <= GATE_TOP_RST;
            r_cfg.cap_numerator <= CAP_NUM_RST;
            r_cfg.cap_offset    <= CAP_OFFSET_RST;
            r_cfg.cap_min       <= CAP_MIN_RST;
            r_cfg.cap_max       <= CAP_MAX_RST;
            r_cfg.height_max    <= HEIGHT_MAX_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GATE_TOP:   r_cfg.gate_top      <= i_cfg_wdata[15:0];
                CFG_CAP_NUM:    r_cfg.cap_numerator <= i_cfg_wdata[NUM_BITS-1:0];
                CFG_CAP_OFFSET: r_cfg.cap_offset    <= i_cfg_wdata[15:0];
                CFG_CAP_MIN:    r_cfg.cap_min       <= i_cfg_wdata[15:0];
                CFG_CAP_MAX:    r_cfg.cap_max       <= i_cfg_wdata[15:0];
                CFG_HEIGHT_MAX: r_cfg.height_max    <= i_cfg_wdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // the front never pushes without an accepted request, so the job queue
    // cannot overflow while full is honored
    assign full   = job_full;
    assign accept = push && !job_full;

    lcm_front #(
        .COUNT_BITS (COUNT_BITS),
        .GATE_BITS  (GATE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gate_top  (r_cfg.gate_top),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_job_push  (job_push),
        .o_job_count (job_count_in)
    );

    // edge counts waiting for the divider
    lcm_queue #(
        .WIDTH (COUNT_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .o_full  (job_full),
        .i_wdata (job_count_in),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_rdata (job_count_out)
    );

    lcm_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job_count (job_count_out),
        .o_job_pop   (job_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_item)
    );

    // finished results waiting for pop
    lcm_queue #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_wdata (res_item),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (res_rdata)
    );

    assign o_out_item = t_out_item'(res_rdata);

endmodule

// ----- tb/lc_capacitive_level_meter_top_tb.sv -----
// lc_capacitive_level_meter_top_tb: self-checking bench for the lc level meter top level
// depends on lcm_pkg and lc_capacitive_level_meter_top; a checker class predicts every gate result

module lc_capacitive_level_meter_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcm_pkg::*;

    // margin for the back to finish a gate result still in flight
    localparam int SETTLE_CYCLES  = 150;
    // longest stretch with no request or result moving before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // receiver hold-off used to back the block up until full rises
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 700;
    localparam int MIN_RANDOM_GATES = 48;
    localparam int MAX_REPORTS    = 10;

    // ------------------------------------------------------------------
    // gate counter and capacitance/level predictor plus result checker
    // ------------------------------------------------------------------
    class level_meter_checker;
        t_cfg        regs;
        logic [23:0] edges_in_gate;
        logic [15:0] ticks_in_gate;
        t_out_item   due[$];
        int          requests_seen;
        int          gates_closed;
        int          no_signal_gates;
        int          bad_cal_gates;
        int          mismatches;

        function new();
            regs.gate_top      = GATE_TOP_RST;
            regs.cap_numerator = CAP_NUM_RST;
            regs.cap_offset    = CAP_OFFSET_RST;
            regs.cap_min       = CAP_MIN_RST;
            regs.cap_max       = CAP_MAX_RST;
            regs.height_max    = HEIGHT_MAX_RST;
            edges_in_gate      = '0;
            ticks_in_gate      = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                CFG_GATE_TOP:   regs.gate_top      = value[15:0];
                CFG_CAP_NUM:    regs.cap_numerator = value[NUM_BITS-1:0];
                CFG_CAP_OFFSET: regs.cap_offset    = value[15:0];
                CFG_CAP_MIN:    regs.cap_min       = value[15:0];
                CFG_CAP_MAX:    regs.cap_max       = value[15:0];
                CFG_HEIGHT_MAX: regs.height_max    = value[15:0];
                default: ;
            endcase
        endfunction

        function int due_count();
            return due.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function string describe(t_out_item r);
            return $sformatf("edges %0d cap %0d level %0d no_signal %0b bad_cal %0b",
                             r.edge_total, r.capacitance, r.level_mm, r.no_signal,
                             r.bad_calibration);
        endfunction

        // one accepted request: count the edge, advance the gate, close it on its top tick
        function void take_request(t_in_item req);
            bit [63:0] count;
            bit [63:0] quo;
            bit [63:0] cap;
            bit [63:0] clamped;
            bit [63:0] lvl;
            bit        none;
            bit        bad;
            t_out_item want;

            requests_seen++;
            if (req.sensor_edge)
                edges_in_gate = edges_in_gate + 1'b1;
            if (!req.gate_tick)
                return;
            if (ticks_in_gate < regs.gate_top) begin
                ticks_in_gate = ticks_in_gate + 1'b1;
                return;
            end

            // gate ends; the edge on this tick is already in the count
            count         = 64'(edges_in_gate);
            edges_in_gate = '0;
            ticks_in_gate = '0;

            none = (count == 0);
            if (none) begin
                cap = 64'hFFFF_FFFF;
            end else begin
                quo = 64'(regs.cap_numerator) / (count * count);
                if (quo > 64'hFFFF_FFFF)
                    quo = 64'hFFFF_FFFF;
                cap = (quo > 64'(regs.cap_offset)) ? quo - 64'(regs.cap_offset) : 64'd0;
            end

            bad = !(regs.cap_max > regs.cap_min);
            if (bad) begin
                lvl = '0;
            end else begin
                clamped = (cap < 64'(regs.cap_min)) ? 64'(regs.cap_min) : cap;
                lvl = 64'(regs.height_max) * (clamped - 64'(regs.cap_min))
                      / 64'(regs.cap_max - regs.cap_min);
                if (lvl > 64'hFFFF)
                    lvl = 64'hFFFF;
            end

            want.edge_total      = count[23:0];
            want.capacitance     = cap[31:0];
            want.level_mm        = lvl[15:0];
            want.no_signal       = none;
            want.bad_calibration = bad;
            due.push_back(want);
            gates_closed++;
            if (none)
                no_signal_gates++;
            if (bad)
                bad_cal_gates++;
        endfunction

        function void check_reading(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                report($sformatf("result with no gate pending: %s", describe(got)));
                return;
            end
            want = due.pop_front();
            if (got.edge_total !== want.edge_total || got.capacitance !== want.capacitance ||
                got.level_mm !== want.level_mm || got.no_signal !== want.no_signal ||
                got.bad_calibration !== want.bad_calibration)
                report($sformatf("expected %s, got %s", describe(want), describe(got)));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block connections
    // ------------------------------------------------------------------
    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     push        = 1'b0;
    logic                     full;
    t_in_item                 i_in_item   = '0;
    logic                     empty;
    logic                     pop         = 1'b0;
    t_out_item                o_out_item;
    logic                     i_cfg_we    = 1'b0;
    t_cfg_idx                 i_cfg_idx   = CFG_GATE_TOP;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    level_meter_checker board;
    t_in_item           req_q[$];     // requests waiting to be offered, head is on the bus
    bit                 allow_idle   = 1'b1;
    int                 hold_trigger = 0; // bumped by the sequence to ask for a long hold-off
    int                 hold_seen    = 0;
    int                 hold_left    = 0;
    int                 send_gap     = 0;
    int                 recv_gap     = 0;
    int                 quiet_cycles = 0;
    int                 settings_used = 0;

    always #5 i_clk = ~i_clk;

    lc_capacitive_level_meter_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_item   (i_in_item),
        .empty       (empty),
        .pop         (pop),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // request side: offer the head of req_q, drop it once taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (push && !full) begin
            board.take_request(i_in_item);
            void'(req_q.pop_front());
            // occasional burst of idle cycles after a request goes in
            if (allow_idle && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 10);
        end
        // an offer that the block refused stays on the bus unchanged
        if (!push || !full) begin
            if (send_gap > 0) begin
                send_gap--;
                push <= 1'b0;
            end else if (req_q.size() != 0) begin
                push      <= 1'b1;
                i_in_item <= req_q[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: check every popped result, stall in bursts or for a long hold
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty)
            board.check_reading(o_out_item);
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 9) == 0) begin
            // a random hold-off that starts in this cycle
            recv_gap = $urandom_range(0, 9);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: nothing moving for too long means the block is stuck
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void queue_item(bit sensor_edge, bit gate_tick);
        t_in_item req;
        req.sensor_edge = sensor_edge;
        req.gate_tick   = gate_tick;
        req_q.push_back(req);
    endfunction

    function automatic t_cfg settings_of(logic [15:0] gate_top, logic [NUM_BITS-1:0] num,
                                         logic [15:0] offset, logic [15:0] cmin,
                                         logic [15:0] cmax, logic [15:0] height);
        t_cfg c;
        c.gate_top      = gate_top;
        c.cap_numerator = num;
        c.cap_offset    = offset;
        c.cap_min       = cmin;
        c.cap_max       = cmax;
        c.height_max    = height;
        return c;
    endfunction

    // all requests taken, all results back, then let the back finish anything in flight
    task automatic wait_drained();
        while (req_q.size() != 0 || push)
            @(posedge i_clk);
        while (board.due_count() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // registers only change with the block idle; the checker follows each write edge
    task automatic start_phase(input t_cfg c, input bit idling);
        t_cfg_idx                 order [6];
        logic [CFG_DATA_BITS-1:0] value [6];
        order = '{CFG_GATE_TOP, CFG_CAP_NUM, CFG_CAP_OFFSET,
                  CFG_CAP_MIN, CFG_CAP_MAX, CFG_HEIGHT_MAX};
        value = '{48'(c.gate_top), 48'(c.cap_numerator), 48'(c.cap_offset),
                  48'(c.cap_min), 48'(c.cap_max), 48'(c.height_max)};
        wait_drained();
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= order[k];
            i_cfg_wdata <= value[k];
            @(posedge i_clk);
            board.set_reg(order[k], value[k]);
        end
        i_cfg_we   <= 1'b0;
        allow_idle <= idling;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        t_cfg c;
        int   n;
        int   edge_pct;
        int   tick_pct;
        int   random_sent;
        int   gates_before;
        bit   last_part;

        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no signal, quotient saturation at the largest numerator, bad calibration,
        // single-tick gates
        start_phase(settings_of(16'd0, '1, 16'd0, 16'd0, 16'd0, 16'hFFFF), 1'b1);
        queue_item(1'b0, 1'b1);
        queue_item(1'b1, 1'b1);
        queue_item(1'b1, 1'b0);
        queue_item(1'b1, 1'b0);
        queue_item(1'b0, 1'b0);
        queue_item(1'b1, 1'b1);

        // edge on the closing tick, offset larger than the quotient, level overflow
        // from the no-signal capacitance
        start_phase(settings_of(16'd2, 48'd1, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF), 1'b1);
        repeat (3) queue_item(1'b1, 1'b1);
        repeat (3) queue_item(1'b0, 1'b1);

        // capacitance below the empty mark is clamped, then a level between empty and full
        start_phase(settings_of(16'd1, 48'd10000, 16'd200, 16'd5000, 16'hFFFF, 16'hFFFF), 1'b1);
        queue_item(1'b1, 1'b0);
        queue_item(1'b1, 1'b1);
        queue_item(1'b0, 1'b1);
        queue_item(1'b1, 1'b1);
        queue_item(1'b0, 1'b1);

        // back-pressure: a gate ends on every request while the receiver holds off,
        // so both queues fill and full stalls the sender
        start_phase(settings_of(16'd0, CAP_NUM_RST, CAP_OFFSET_RST, 16'd0, 16'hFFFF,
                                16'hFFFF), 1'b1);
        hold_trigger <= hold_trigger + 1;
        repeat (80) queue_item(1'($urandom_range(0, 1)), 1'b1);

        // longer gate window with the nominal coil constant
        start_phase(settings_of(16'd199, CAP_NUM_RST, CAP_OFFSET_RST, 16'd20000, 16'd30000,
                                16'd2000), 1'b1);
        repeat (200) queue_item(1'($urandom_range(0, 1)), 1'b1);

        // random register settings, each followed by a burst of random samples
        random_sent  = 0;
        gates_before = board.gates_closed;
        while (random_sent < RANDOM_ITEMS ||
               board.gates_closed - gates_before < MIN_RANDOM_GATES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: c.gate_top = 16'($urandom_range(0, 3));
                5, 6, 7:       c.gate_top = 16'($urandom_range(4, 20));
                default:       c.gate_top = 16'($urandom_range(21, 300));
            endcase
            case ($urandom_range(0, 4))
                0:       c.cap_numerator = '1;
                1:       c.cap_numerator = 48'($urandom_range(1, 1000));
                2:       c.cap_numerator = 48'({$urandom(), $urandom()});
                3:       c.cap_numerator = CAP_NUM_RST;
                default: c.cap_numerator = 48'($urandom_range(1, 65535))
                                           * 48'($urandom_range(1, 2000));
            endcase
            case ($urandom_range(0, 3))
                0:       c.cap_offset = '0;
                1:       c.cap_offset = '1;
                2:       c.cap_offset = 16'($urandom());
                default: c.cap_offset = 16'($urandom_range(0, 500));
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    // full mark at or below the empty mark
                    c.cap_max = 16'($urandom());
                    c.cap_min = c.cap_max + 16'($urandom_range(0, 65535 - c.cap_max));
                end
                1: begin
                    c.cap_min = 16'($urandom());
                    c.cap_max = 16'($urandom());
                    if (c.cap_min > c.cap_max) begin
                        c.cap_min = c.cap_min ^ c.cap_max;
                        c.cap_max = c.cap_min ^ c.cap_max;
                        c.cap_min = c.cap_min ^ c.cap_max;
                    end
                end
                2: begin
                    c.cap_min = '0;
                    c.cap_max = '1;
                end
                default: begin
                    c.cap_min = 16'($urandom_range(0, 2000));
                    c.cap_max = c.cap_min + 16'($urandom_range(1, 3000));
                end
            endcase
            case ($urandom_range(0, 3))
                0:       c.height_max = '0;
                1:       c.height_max = '1;
                default: c.height_max = 16'($urandom());
            endcase

            // no idling at all in the last quarter, and now and then in between
            last_part = (random_sent >= (RANDOM_ITEMS * 3) / 4);
            start_phase(c, !last_part && $urandom_range(0, 3) != 0);

            n        = $urandom_range(30, 120);
            edge_pct = $urandom_range(0, 100);
            tick_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 100);
            for (int k = 0; k < n; k++)
                queue_item($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < tick_pct);
            random_sent += n;
        end

        wait_drained();
        if (board.due_count() != 0)
            board.report($sformatf("%0d gate results never arrived", board.due_count()));

        $display("covered %0d samples and %0d gate results over %0d register settings",
                 board.requests_seen, board.gates_closed, settings_used);
        $display("%0d gates with no signal, %0d with bad calibration, %0d mismatches",
                 board.no_signal_gates, board.bad_cal_gates, board.mismatches);
        if (board.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
